/* rtl/ftr_pkg.sv */
// ----------------------------------------------------------------------------
// ftr_pkg
// Types and codes shared by the file-transfer receiver modules.
// ----------------------------------------------------------------------------
package ftr_pkg;

	// Receiver phase.
	typedef enum logic [2:0] {
		PH_WAITING   = 3'd0,
		PH_CONNECTED = 3'd1,
		PH_OFFERED   = 3'd2,
		PH_RECEIVING = 3'd3,
		PH_DONE      = 3'd4,
		PH_ERROR     = 3'd5
	} phase_t;

	// Error raised by one event.
	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_TXN_CLASH   = 4'd1,
		ERR_OFFER_PHASE = 4'd2,
		ERR_VERSION     = 4'd3,
		ERR_OPEN        = 4'd4,
		ERR_CHUNK_PHASE = 4'd5,
		ERR_OFFSET      = 4'd6,
		ERR_WRITE       = 4'd7,
		ERR_OVERRUN     = 4'd8,
		ERR_CLOSE       = 4'd9
	} err_t;

	// Event kinds.
	typedef enum logic [1:0] {
		FN_CONNECT = 2'd0,
		FN_DROP    = 2'd1,
		FN_MESSAGE = 2'd2,
		FN_RESTART = 2'd3
	} func_t;

	localparam logic [7:0]  MSG_OFFER     = 8'd0;
	localparam logic [7:0]  MSG_CHUNK     = 8'd2;
	localparam logic [15:0] PROTO_VERSION = 16'd1;

	// One input event.
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  msg_type;
		logic [31:0] txn_id;
		logic [15:0] proto_version;
		logic [31:0] file_length;
		logic [31:0] chunk_offset;
		logic [15:0] payload_len;
		logic        store_ok;
		logic        close_ok;
	} ftr_item_t;

	// One result of an event.
	typedef struct packed {
		phase_t      phase;
		logic        ack_valid;
		logic [31:0] ack_txn;
		err_t        error_code;
		logic        start_advertise;
		logic        drop_link;
		logic [31:0] bytes_received;
	} ftr_result_t;

endpackage

/* rtl/ftr_in_if.sv */
// ----------------------------------------------------------------------------
// ftr_in_if
// Event channel into the file-transfer receiver: valid, ready and payload.
// ----------------------------------------------------------------------------
interface ftr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  msg_type;
	logic [31:0] txn_id;
	logic [15:0] proto_version;
	logic [31:0] file_length;
	logic [31:0] chunk_offset;
	logic [15:0] payload_len;
	logic        store_ok;
	logic        close_ok;

	modport source (
		output valid, func, msg_type, txn_id, proto_version, file_length,
		       chunk_offset, payload_len, store_ok, close_ok,
		input  ready
	);
	modport sink (
		input  valid, func, msg_type, txn_id, proto_version, file_length,
		       chunk_offset, payload_len, store_ok, close_ok,
		output ready
	);
endinterface

/* rtl/ftr_out_if.sv */
// ----------------------------------------------------------------------------
// ftr_out_if
// Result channel out of the file-transfer receiver: valid, ready and payload.
// ----------------------------------------------------------------------------
interface ftr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  phase;
	logic        ack_valid;
	logic [31:0] ack_txn;
	logic [3:0]  error_code;
	logic        start_advertise;
	logic        drop_link;
	logic [31:0] bytes_received;

	modport source (
		output valid, phase, ack_valid, ack_txn, error_code, start_advertise,
		       drop_link, bytes_received,
		input  ready
	);
	modport sink (
		input  valid, phase, ack_valid, ack_txn, error_code, start_advertise,
		       drop_link, bytes_received,
		output ready
	);
endinterface

/* rtl/ftr_core.sv */
// ----------------------------------------------------------------------------
// ftr_core
// Protocol state of the receiver and the checks applied to one event.
// ----------------------------------------------------------------------------
module ftr_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ftr_pkg::ftr_item_t  item,
	output ftr_pkg::ftr_result_t result
);
	import ftr_pkg::*;

	localparam int CMPW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	phase_t                 phase_q, phase_d, tgt;
	logic [31:0]            txn_q, txn_d;
	logic [COUNT_WIDTH-1:0] total_q, total_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic                   link_q, link_d;
	logic [COUNT_WIDTH:0]   sum;
	logic [CMPW-1:0]        count_ext;
	err_t                   err;
	logic                   adv, drop, ack;
	logic [31:0]            ack_txn;

	always_comb begin
		sum       = {1'b0, count_q} + (COUNT_WIDTH+1)'(item.payload_len);
		count_ext = CMPW'(count_q);
	end

	always_comb begin
		tgt     = phase_q;
		txn_d   = txn_q;
		total_d = total_q;
		count_d = count_q;
		link_d  = link_q;
		err     = ERR_NONE;
		ack     = 1'b0;
		ack_txn = '0;
		adv     = 1'b0;
		drop    = 1'b0;

		case (func_t'(item.func))
			FN_CONNECT: begin
				link_d = 1'b1;
				if (phase_q != PH_ERROR) tgt = PH_CONNECTED;
			end
			FN_DROP: begin
				link_d = 1'b0;
				if (phase_q != PH_ERROR) tgt = PH_WAITING;
			end
			FN_RESTART: begin
				if (phase_q == PH_ERROR) tgt = PH_WAITING;
			end
			FN_MESSAGE: begin
				if (phase_q != PH_ERROR) begin
					if (txn_q != '0 && txn_q != item.txn_id) begin
						err = ERR_TXN_CLASH;
					end else if (item.msg_type == MSG_OFFER) begin
						if (phase_q != PH_CONNECTED) begin
							err = ERR_OFFER_PHASE;
						end else if (item.proto_version != PROTO_VERSION) begin
							err = ERR_VERSION;
						end else begin
							total_d = COUNT_WIDTH'(item.file_length);
							if (!item.store_ok) begin
								err = ERR_OPEN;
							end else begin
								txn_d   = item.txn_id;
								tgt     = PH_OFFERED;
								ack     = 1'b1;
								ack_txn = item.txn_id;
							end
						end
					end else if (item.msg_type == MSG_CHUNK) begin
						if (phase_q != PH_OFFERED && phase_q != PH_RECEIVING) begin
							err = ERR_CHUNK_PHASE;
						end else if (CMPW'(item.chunk_offset) != count_ext) begin
							err = ERR_OFFSET;
						end else if (!item.store_ok) begin
							err = ERR_WRITE;
						end else if (sum[COUNT_WIDTH]) begin
							// The sum no longer fits: saturate and flag overrun.
							count_d = '1;
							err     = ERR_OVERRUN;
						end else begin
							count_d = sum[COUNT_WIDTH-1:0];
							if (sum[COUNT_WIDTH-1:0] > total_q) begin
								err = ERR_OVERRUN;
							end else if (sum[COUNT_WIDTH-1:0] == total_q) begin
								if (!item.close_ok) err = ERR_CLOSE;
								else tgt = PH_DONE;
							end else begin
								tgt = PH_RECEIVING;
							end
						end
					end
				end
			end
			default: ;
		endcase

		if (err != ERR_NONE) tgt = PH_ERROR;

		// Side effects of a phase change; staying put changes nothing.
		if (tgt != phase_q) begin
			case (tgt)
				PH_WAITING: begin
					adv   = 1'b1;
					txn_d = '0;
				end
				PH_OFFERED: count_d = '0;
				PH_ERROR:   drop = link_q;
				default: ;
			endcase
		end
		phase_d = tgt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAITING;
			txn_q   <= '0;
			total_q <= '0;
			count_q <= '0;
			link_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			txn_q   <= txn_d;
			total_q <= total_d;
			count_q <= count_d;
			link_q  <= link_d;
		end
	end

	logic [CMPW-1:0] count_out;
	always_comb begin
		count_out                = CMPW'(count_d);
		result.phase             = phase_d;
		result.ack_valid         = ack;
		result.ack_txn           = ack_txn;
		result.error_code        = err;
		result.start_advertise   = adv;
		result.drop_link         = drop;
		result.bytes_received    = count_out[31:0];
	end

endmodule

/* rtl/file_transfer_receiver_fsm.sv */
// ----------------------------------------------------------------------------
// file_transfer_receiver_fsm
// Receiver-side controller of a chunked file-transfer protocol.
// ----------------------------------------------------------------------------
// The block takes one event per transfer on req (link connected, link dropped,
// protocol message or user restart) and returns exactly one result per event
// on rsp, in order. An event is first captured in an input register; from
// there the protocol checks and the byte-count add are evaluated against the
// current state, and when the output register is free or being emptied the
// state is updated and the result is captured in the output register. The
// output register parts the two sides, so a new event is taken in every
// cycle as long as results are taken, giving a sustained rate of one event
// per clock. The rate is set by the single state update per event, which
// each following event depends on. The parameter COUNT_WIDTH (16 to 64) sets
// the width of the expected total and received count; bytes_received reports
// the low 32 bits of the count.
// Errors are sticky until a restart event, and error_code, start_advertise
// and drop_link are pulses that belong to the single result that raised them.
// ----------------------------------------------------------------------------
module file_transfer_receiver_fsm #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	ftr_in_if.sink  req,
	ftr_out_if.source rsp
);
	import ftr_pkg::*;

	ftr_item_t   item_s1;
	logic        valid_s1;
	ftr_result_t res;
	ftr_result_t result_q;
	logic        out_valid_q;
	logic        advance;
	logic        take;

	// The staged event moves on whenever the output register is free or
	// being emptied in this cycle.
	assign advance = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register, loaded on each accepted transfer.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.func          <= req.func;
			item_s1.msg_type      <= req.msg_type;
			item_s1.txn_id        <= req.txn_id;
			item_s1.proto_version <= req.proto_version;
			item_s1.file_length   <= req.file_length;
			item_s1.chunk_offset  <= req.chunk_offset;
			item_s1.payload_len   <= req.payload_len;
			item_s1.store_ok      <= req.store_ok;
			item_s1.close_ok      <= req.close_ok;
		end
	end

	ftr_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.phase           = result_q.phase;
	assign rsp.ack_valid       = result_q.ack_valid;
	assign rsp.ack_txn         = result_q.ack_txn;
	assign rsp.error_code      = result_q.error_code;
	assign rsp.start_advertise = result_q.start_advertise;
	assign rsp.drop_link       = result_q.drop_link;
	assign rsp.bytes_received  = result_q.bytes_received;

endmodule

/* test/file_transfer_receiver_fsm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_transfer_receiver_fsm_checker
// Watches both channels of the file-transfer receiver, works out the result
// of every accepted event from its own copy of the receiver state, and
// compares each returned result with the oldest one still due.
// ----------------------------------------------------------------------------
module file_transfer_receiver_fsm_checker
	import ftr_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	ftr_in_if    req,
	ftr_out_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam logic [63:0] COUNT_MASK = (COUNT_WIDTH >= 64) ? {64{1'b1}} :
		((64'd1 << COUNT_WIDTH) - 64'd1);

	phase_t      cur_phase;
	logic [31:0] cur_txn;
	logic [63:0] total_bytes;
	logic [63:0] got_bytes;
	logic        link_is_up;

	logic        adv_pulse;
	logic        drop_pulse;
	err_t        raised;

	ftr_result_t results_due[$];

	// A move into the current phase changes nothing and gives no pulse.
	task automatic enter_phase(input phase_t nxt);
		if (cur_phase != nxt) begin
			if (nxt == PH_WAITING) begin
				adv_pulse = 1'b1;
				cur_txn   = '0;
			end else if (nxt == PH_OFFERED) begin
				got_bytes = '0;
			end else if (nxt == PH_ERROR && link_is_up) begin
				drop_pulse = 1'b1;
			end
			cur_phase = nxt;
		end
	endtask

	task automatic raise_error(input err_t code);
		raised = code;
		enter_phase(PH_ERROR);
	endtask

	task automatic apply_event(input ftr_item_t ev, output ftr_result_t res);
		logic [64:0] sum;
		logic        acked;
		acked      = 1'b0;
		adv_pulse  = 1'b0;
		drop_pulse = 1'b0;
		raised     = ERR_NONE;
		case (func_t'(ev.func))
			FN_CONNECT: begin
				link_is_up = 1'b1;
				if (cur_phase != PH_ERROR)
					enter_phase(PH_CONNECTED);
			end
			FN_DROP: begin
				link_is_up = 1'b0;
				if (cur_phase != PH_ERROR)
					enter_phase(PH_WAITING);
			end
			FN_RESTART: begin
				if (cur_phase == PH_ERROR)
					enter_phase(PH_WAITING);
			end
			default: begin
				if (cur_phase == PH_ERROR) begin
					// Errors are sticky: messages are dropped until a restart.
				end else if (cur_txn != '0 && cur_txn != ev.txn_id) begin
					raise_error(ERR_TXN_CLASH);
				end else if (ev.msg_type == MSG_OFFER) begin
					if (cur_phase != PH_CONNECTED) begin
						raise_error(ERR_OFFER_PHASE);
					end else if (ev.proto_version != PROTO_VERSION) begin
						raise_error(ERR_VERSION);
					end else begin
						total_bytes = {32'd0, ev.file_length} & COUNT_MASK;
						if (!ev.store_ok) begin
							raise_error(ERR_OPEN);
						end else begin
							cur_txn = ev.txn_id;
							enter_phase(PH_OFFERED);
							acked = 1'b1;
						end
					end
				end else if (ev.msg_type == MSG_CHUNK) begin
					if (cur_phase != PH_OFFERED && cur_phase != PH_RECEIVING) begin
						raise_error(ERR_CHUNK_PHASE);
					end else if ({32'd0, ev.chunk_offset} != got_bytes) begin
						raise_error(ERR_OFFSET);
					end else if (!ev.store_ok) begin
						raise_error(ERR_WRITE);
					end else begin
						sum = {1'b0, got_bytes} + {49'd0, ev.payload_len};
						if (sum > {1'b0, COUNT_MASK}) begin
							// The count saturates rather than wrapping.
							got_bytes = COUNT_MASK;
							raise_error(ERR_OVERRUN);
						end else begin
							got_bytes = sum[63:0];
							if (got_bytes > total_bytes) begin
								raise_error(ERR_OVERRUN);
							end else if (got_bytes == total_bytes) begin
								if (!ev.close_ok)
									raise_error(ERR_CLOSE);
								else
									enter_phase(PH_DONE);
							end else begin
								enter_phase(PH_RECEIVING);
							end
						end
					end
				end
			end
		endcase
		res.phase           = cur_phase;
		res.ack_valid       = acked;
		res.ack_txn         = acked ? ev.txn_id : 32'd0;
		res.error_code      = raised;
		res.start_advertise = adv_pulse;
		res.drop_link       = drop_pulse;
		res.bytes_received  = got_bytes[31:0];
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
			mismatches = mismatches + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ftr_item_t   ev;
		ftr_result_t want;
		if (!arst_n) begin
			cur_phase   = PH_WAITING;
			cur_txn     = '0;
			total_bytes = '0;
			got_bytes   = '0;
			link_is_up  = 1'b0;
			results_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with none expected, expected nothing, actual phase %0d",
						$time, rsp.phase);
					mismatches = mismatches + 1;
				end else begin
					want = results_due.pop_front();
					check_field("phase", 32'(want.phase), 32'(rsp.phase));
					check_field("ack_valid", 32'(want.ack_valid), 32'(rsp.ack_valid));
					check_field("ack_txn", want.ack_txn, rsp.ack_txn);
					check_field("error_code", 32'(want.error_code),
						32'(rsp.error_code));
					check_field("start_advertise", 32'(want.start_advertise),
						32'(rsp.start_advertise));
					check_field("drop_link", 32'(want.drop_link),
						32'(rsp.drop_link));
					check_field("bytes_received", want.bytes_received, rsp.bytes_received);
				end
			end
			if (req.valid && req.ready) begin
				ev.func          = req.func;
				ev.msg_type      = req.msg_type;
				ev.txn_id        = req.txn_id;
				ev.proto_version = req.proto_version;
				ev.file_length   = req.file_length;
				ev.chunk_offset  = req.chunk_offset;
				ev.payload_len   = req.payload_len;
				ev.store_ok      = req.store_ok;
				ev.close_ok      = req.close_ok;
				apply_event(ev, want);
				results_due.push_back(want);
			end
		end
		outstanding = results_due.size();
	end

endmodule

/* test/file_transfer_receiver_fsm_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_transfer_receiver_fsm_tb
// Drives link events and offer and chunk messages into the file-transfer
// receiver and collects its results, with random idling on both sides and a
// long hold-off on the result side; the checker alongside judges every result.
// ----------------------------------------------------------------------------
module file_transfer_receiver_fsm_tb;
	import ftr_pkg::*;

	localparam int ITEM_TARGET = 900;
	localparam int CYCLE_LIMIT = 100000;
	localparam int LONG_HOLD   = 80;
	localparam int DRAIN_WAIT  = 10;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ftr_in_if  req ();
	ftr_out_if rsp ();

	int mismatches;
	int outstanding;

	// Events sent so far; this paces idling and hold-offs.
	int rnd_sent = 0;

	// Both sides idle in random bursts, except in a stretch in the middle and
	// in the last part of the run, where transfers go back to back.
	logic idle_on;
	assign idle_on = rnd_sent < 760 && !(rnd_sent >= 400 && rnd_sent < 480);

	file_transfer_receiver_fsm #(
		.COUNT_WIDTH(32)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	file_transfer_receiver_fsm_checker #(
		.COUNT_WIDTH(32)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A fully random event: every field, every bit.
	function automatic ftr_item_t random_event();
		logic [159:0] bits;
		bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		return bits[$bits(ftr_item_t)-1:0];
	endfunction

	// Offers one event and holds it until the block takes it. Valid is only
	// lowered when an idle burst goes in front of the event.
	task automatic push_event(input ftr_item_t ev);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.func          <= ev.func;
		req.msg_type      <= ev.msg_type;
		req.txn_id        <= ev.txn_id;
		req.proto_version <= ev.proto_version;
		req.file_length   <= ev.file_length;
		req.chunk_offset  <= ev.chunk_offset;
		req.payload_len   <= ev.payload_len;
		req.store_ok      <= ev.store_ok;
		req.close_ok      <= ev.close_ok;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		rnd_sent++;
	endtask

	// Link and restart events; the message fields are random and unused.
	task automatic send_ctrl(input func_t f);
		ftr_item_t ev;
		ev      = random_event();
		ev.func = f;
		push_event(ev);
	endtask

	task automatic send_offer(input logic [31:0] txn, input logic [31:0] ver,
			input logic [31:0] flen, input logic ok);
		ftr_item_t ev;
		ev               = random_event();
		ev.func          = FN_MESSAGE;
		ev.msg_type      = MSG_OFFER;
		ev.txn_id        = txn;
		ev.proto_version = ver[15:0];
		ev.file_length   = flen;
		ev.store_ok      = ok;
		push_event(ev);
	endtask

	task automatic send_chunk(input logic [31:0] txn, input logic [31:0] off,
			input logic [31:0] plen, input logic ok, input logic closed);
		ftr_item_t ev;
		ev              = random_event();
		ev.func         = FN_MESSAGE;
		ev.msg_type     = MSG_CHUNK;
		ev.txn_id       = txn;
		ev.chunk_offset = off;
		ev.payload_len  = plen[15:0];
		ev.store_ok     = ok;
		ev.close_ok     = closed;
		push_event(ev);
	endtask

	// A message of a kind the receiver does not handle.
	task automatic send_other(input logic [31:0] txn);
		ftr_item_t ev;
		ev        = random_event();
		ev.func   = FN_MESSAGE;
		ev.txn_id = txn;
		if (ev.msg_type == MSG_OFFER || ev.msg_type == MSG_CHUNK)
			ev.msg_type = 8'hFF;
		push_event(ev);
	endtask

	// One transfer session: usually a clean start, an offer, then contiguous
	// chunks up to the announced length. Now and then a fault is slipped in
	// (overrun, gap in the offsets, failed write or close, foreign
	// transaction, phase violation, link loss), after which the session ends.
	task automatic run_session();
		logic [31:0] txn;
		logic [31:0] flen;
		logic [31:0] pos;
		logic [31:0] left;
		logic [31:0] cap;
		logic [31:0] plen;
		int          nchunks;
		int          pick;
		bit          finished;
		// Skipping the clean start now and then leaves an old transaction in
		// place, so that the next offer clashes with it.
		if ($urandom_range(0, 9) != 0) begin
			send_ctrl(FN_RESTART);
			send_ctrl(FN_DROP);
		end
		send_ctrl(FN_CONNECT);
		txn  = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom();
		flen = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3000);
		send_offer(txn, ($urandom_range(0, 11) == 0) ? $urandom() : 32'd1, flen,
			$urandom_range(0, 15) != 0);
		pos      = '0;
		finished = 1'b0;
		nchunks  = $urandom_range(1, 12);
		for (int i = 0; i < nchunks && !finished; i++) begin
			left = flen - pos;
			cap  = (left < 32'd1000) ? left : 32'd1000;
			plen = $urandom_range(0, cap);
			if (i == nchunks - 1 && left <= 32'hFFFF)
				plen = left;
			pick     = $urandom_range(0, 59);
			finished = 1'b1;
			case (pick)
				0: send_chunk(txn, pos,
					(left < 32'd65000) ? left + $urandom_range(1, 64) : 32'hFFFF, 1'b1, 1'b1);
				1: send_chunk(txn,
					($urandom_range(0, 1) == 0) ? pos + $urandom_range(1, 1000) : $urandom(),
					plen, 1'b1, 1'b1);
				2: send_chunk(txn, pos, plen, 1'b0, 1'b1);
				3: send_chunk(txn, pos, (left <= 32'hFFFF) ? left : plen, 1'b1, 1'b0);
				4: send_chunk(txn ^ (32'd1 << $urandom_range(0, 31)), pos, plen, 1'b1, 1'b1);
				5: begin
					// Reconnecting mid-file falls back to connected, so the
					// chunk that follows is out of phase.
					send_ctrl(FN_CONNECT);
					send_chunk(txn, pos, plen, 1'b1, 1'b1);
				end
				6: send_offer(txn, 32'd1, flen, 1'b1);
				7: send_ctrl(FN_DROP);
				8, 9: begin
					push_event(random_event());
					finished = 1'b0;
				end
				10: begin
					send_other(txn);
					finished = 1'b0;
				end
				default: begin
					send_chunk(txn, pos, plen, 1'b1, 1'b1);
					pos      = pos + plen;
					finished = (pos == flen);
				end
			endcase
		end
	endtask

	// Result side: random stalls, and at two points a long hold-off during
	// which the sender keeps offering, so the block fills up and stops
	// taking events.
	initial begin : result_sink
		int stall;
		int hold_left;
		int next_hold;
		stall     = 0;
		hold_left = 0;
		next_hold = 250;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (next_hold <= 550 && rnd_sent >= next_hold) begin
				hold_left = LONG_HOLD;
				next_hold = next_hold + 300;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 7);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		req.valid         <= 1'b0;
		req.func          <= FN_CONNECT;
		req.msg_type      <= MSG_OFFER;
		req.txn_id        <= '0;
		req.proto_version <= '0;
		req.file_length   <= '0;
		req.chunk_offset  <= '0;
		req.payload_len   <= '0;
		req.store_ok      <= 1'b0;
		req.close_ok      <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A restart outside error does nothing, and a drop
		// while already waiting gives no advertise pulse.
		send_ctrl(FN_RESTART);
		send_ctrl(FN_DROP);
		// A chunk while waiting is out of phase; the link is down, so there
		// is no drop pulse. A connect in error only brings the link up.
		send_chunk(32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
		send_ctrl(FN_CONNECT);
		send_ctrl(FN_RESTART);
		send_ctrl(FN_CONNECT);
		// Wrong version with the link up: error plus drop pulse.
		send_offer(32'd1, 32'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_ctrl(FN_RESTART);
		send_ctrl(FN_CONNECT);
		// Storage fails to open after the length has been taken.
		send_offer(32'd1, 32'd1, 32'hFFFF_FFFF, 1'b0);
		send_ctrl(FN_RESTART);
		send_ctrl(FN_CONNECT);
		send_offer(32'hFFFF_FFFF, 32'd1, 32'd100, 1'b1);
		send_other(32'hFFFF_FFFF);
		send_chunk(32'hFFFF_FFFF, 32'd0, 32'd60, 1'b1, 1'b1);
		// A connect mid-file returns to connected and keeps the transaction;
		// the fresh offer then clears the byte count.
		send_ctrl(FN_CONNECT);
		send_offer(32'hFFFF_FFFF, 32'd1, 32'd40, 1'b1);
		// The file completes but cannot be closed: the full count is shown.
		send_chunk(32'hFFFF_FFFF, 32'd0, 32'd40, 1'b1, 1'b0);
		send_ctrl(FN_RESTART);
		send_ctrl(FN_CONNECT);
		// An empty file completes on an empty chunk; a second offer is then
		// out of phase.
		send_offer(32'h8000_0000, 32'd1, 32'd0, 1'b1);
		send_chunk(32'h8000_0000, 32'd0, 32'd0, 1'b1, 1'b1);
		send_offer(32'h8000_0000, 32'd1, 32'd0, 1'b1);
		send_ctrl(FN_DROP);

		while (rnd_sent < ITEM_TARGET)
			run_session();

		req.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
